// ===== rtl/stack_machine_executor_macros.svh =====
// Assertion macros shared by the stack machine executor RTL.
`ifndef STACK_MACHINE_EXECUTOR_MACROS_SVH
`define STACK_MACHINE_EXECUTOR_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, checked at every rising edge outside reset.
`define SME_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("stack machine executor check failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define SME_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("stack machine executor check failed");

`else

`define SME_ASSERT_NOW(label, ante, cons)
`define SME_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// ===== rtl/sme_pkg.sv =====
// Types and constants for the stack machine executor.
package sme_pkg;

  localparam int WORD_W   = 64;
  localparam int OP_W     = 4;
  localparam int STATUS_W = 3;
  localparam int DEPTH_W  = 9;
  localparam int ITER_W   = $clog2(WORD_W);

  typedef logic [WORD_W-1:0]   word_t;
  typedef logic [OP_W-1:0]     op_t;
  typedef logic [STATUS_W-1:0] status_t;

  // Instruction codes.
  localparam op_t OP_HALT    = 4'd0;
  localparam op_t OP_ADD     = 4'd1;
  localparam op_t OP_SUB     = 4'd2;
  localparam op_t OP_MUL     = 4'd3;
  localparam op_t OP_DIV     = 4'd4;
  localparam op_t OP_PUSH    = 4'd5;
  localparam op_t OP_DISPLAY = 4'd6;
  localparam op_t OP_PEEK    = 4'd7;

  // Result status codes.
  localparam status_t ST_DONE    = 3'd0;
  localparam status_t ST_HALTED  = 3'd1;
  localparam status_t ST_SHOWN   = 3'd2;
  localparam status_t ST_UNDER   = 3'd3;
  localparam status_t ST_OVER    = 3'd4;
  localparam status_t ST_DIVZERO = 3'd5;

endpackage

// ===== rtl/stack_machine_executor.sv =====
// Stack machine executor: a 64-bit operand stack driven by one instruction per transfer.
//
// The input channel (in_valid, in_stall, operation, operand) carries one instruction per
// transfer; the output channel (out_valid, out_stall, status, shown_value, depth) returns
// exactly one result per instruction, in order. The block works on one instruction at a
// time and holds in_stall high from the transfer until its result is registered.
// Steps per instruction: push, halt, unused codes and errors found at decode go straight to
// the result; peek, display and divide by zero read the top entry first; add and sub read
// both operands, add or subtract and write back; mul does one add per multiplier bit on the
// shared 65-bit adder; div does two sign fixes, one trial subtract per quotient bit and one
// final negate.
// The result is registered on the output in S_EMIT once the work ends and the output is free. All arithmetic
// runs through a single shared adder/subtractor; the stack sits in a memory with one write
// port and one registered read port, so the two operands are read on consecutive cycles.
// A synchronous reset empties the stack and clears the halt flag; stack contents are not
// cleared and need no sweep. While the receiver stalls, the result holds; the next
// instruction may be taken meanwhile, but its result waits until the output frees.
module stack_machine_executor #(
  parameter int STACK_DEPTH = 256
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [sme_pkg::OP_W-1:0]             operation,
  input  logic signed [sme_pkg::WORD_W-1:0]    operand,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [sme_pkg::STATUS_W-1:0]         status,
  output logic signed [sme_pkg::WORD_W-1:0]    shown_value,
  output logic [sme_pkg::DEPTH_W-1:0]          depth
);

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int W  = sme_pkg::WORD_W;

  // Sequencer state codes.
  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_DECODE   = 4'd1;
  localparam logic [3:0] S_RD_TOP   = 4'd2;
  localparam logic [3:0] S_RD_BELOW = 4'd3;
  localparam logic [3:0] S_MUL      = 4'd4;
  localparam logic [3:0] S_ABS_A    = 4'd5;
  localparam logic [3:0] S_ABS_B    = 4'd6;
  localparam logic [3:0] S_DIV      = 4'd7;
  localparam logic [3:0] S_FIX      = 4'd8;
  localparam logic [3:0] S_WB       = 4'd9;
  localparam logic [3:0] S_EMIT     = 4'd10;

  localparam logic [sme_pkg::ITER_W-1:0] ITER_LAST = sme_pkg::ITER_W'(W - 1);

  logic [3:0]                  state;
  logic [CW-1:0]               count;
  logic                        halted;
  sme_pkg::op_t                op;
  sme_pkg::status_t            res_status;
  sme_pkg::word_t              acc;
  sme_pkg::word_t              opa;
  sme_pkg::word_t              opb;
  sme_pkg::word_t              rem;
  sme_pkg::word_t              top;
  logic                        neg;
  logic [sme_pkg::ITER_W-1:0]  iter;

  // Stack memory with one write port and a registered read port.
  sme_pkg::word_t              mem [STACK_DEPTH];
  sme_pkg::word_t              rd_data;
  logic                        mem_we;
  logic [AW-1:0]               wr_addr;
  sme_pkg::word_t              wr_data;
  logic                        rd_en;
  logic [AW-1:0]               rd_addr;

  logic [CW-1:0]               count_m1;
  logic [CW-1:0]               count_m2;
  logic                        full;
  logic                        is_display;

  // Shared adder/subtractor operands and result.
  logic [W:0]                  add_a;
  sme_pkg::word_t              add_b;
  logic                        add_sub;
  logic [W:0]                  add_b_ext;
  logic [W:0]                  add_sum;
  logic                        div_ge;

  assign count_m1   = count - CW'(1);
  assign count_m2   = count - CW'(2);
  assign full       = (count >= CW'(STACK_DEPTH));
  assign is_display = (op == sme_pkg::OP_DISPLAY);
  assign in_stall   = (state != S_IDLE);

  // Memory port control: push writes at the count, a finished operation writes below it.
  always_comb begin
    mem_we  = ((state == S_DECODE) && !halted && (op == sme_pkg::OP_PUSH) && !full)
              || (state == S_WB);
    wr_addr = (state == S_WB) ? count_m2[AW-1:0] : count[AW-1:0];
    wr_data = (state == S_WB) ? acc : opb;
    rd_en   = (state == S_DECODE) || (state == S_RD_TOP);
    rd_addr = (state == S_RD_TOP) ? count_m2[AW-1:0] : count_m1[AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // Operand selection for the shared adder in each sequencer step.
  always_comb begin
    add_a   = '0;
    add_b   = '0;
    add_sub = 1'b0;
    unique case (state)
      S_RD_BELOW: begin
        add_a   = {1'b0, rd_data};
        add_b   = top;
        add_sub = (op == sme_pkg::OP_SUB);
      end
      S_MUL: begin
        add_a = {1'b0, acc};
        add_b = opb[0] ? opa : '0;
      end
      S_ABS_A, S_FIX: begin
        add_b   = opb;
        add_sub = 1'b1;
      end
      S_ABS_B: begin
        add_b   = opa;
        add_sub = 1'b1;
      end
      S_DIV: begin
        add_a   = {rem, opb[W-1]};
        add_b   = opa;
        add_sub = 1'b1;
      end
      default: begin
        add_sub = 1'b0;
      end
    endcase
  end

  assign add_b_ext = {1'b0, add_b};
  assign add_sum   = add_a + (add_sub ? ~add_b_ext : add_b_ext) + (W + 1)'(add_sub);
  assign div_ge    = ~add_sum[W];

  // Sequencer and datapath registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      halted    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // A result leaves here unless a new one is loaded in the same cycle.
      if (out_valid && !out_stall && (state != S_EMIT)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            op    <= operation;
            opb   <= operand;
            state <= S_DECODE;
          end
        end
        S_DECODE: begin
          acc <= '0;
          if (halted) begin
            res_status <= sme_pkg::ST_HALTED;
            state      <= S_EMIT;
          end else begin
            unique case (op) inside
              sme_pkg::OP_HALT: begin
                halted     <= 1'b1;
                res_status <= sme_pkg::ST_HALTED;
                state      <= S_EMIT;
              end
              sme_pkg::OP_ADD, sme_pkg::OP_SUB, sme_pkg::OP_MUL, sme_pkg::OP_DIV: begin
                if (count < CW'(2)) begin
                  res_status <= sme_pkg::ST_UNDER;
                  state      <= S_EMIT;
                end else begin
                  state <= S_RD_TOP;
                end
              end
              sme_pkg::OP_PUSH: begin
                if (full) begin
                  res_status <= sme_pkg::ST_OVER;
                end else begin
                  count      <= count + CW'(1);
                  res_status <= sme_pkg::ST_DONE;
                end
                state <= S_EMIT;
              end
              sme_pkg::OP_DISPLAY, sme_pkg::OP_PEEK: begin
                if (count == '0) begin
                  res_status <= sme_pkg::ST_UNDER;
                  state      <= S_EMIT;
                end else begin
                  state <= S_RD_TOP;
                end
              end
              default: begin
                res_status <= sme_pkg::ST_DONE;
                state      <= S_EMIT;
              end
            endcase
          end
        end
        S_RD_TOP: begin
          // The top entry is on the read port; the entry below is requested now.
          if (is_display || (op == sme_pkg::OP_PEEK)) begin
            acc        <= rd_data;
            res_status <= sme_pkg::ST_SHOWN;
            if (is_display) begin
              count <= count_m1;
            end
            state <= S_EMIT;
          end else if ((op == sme_pkg::OP_DIV) && (rd_data == '0)) begin
            res_status <= sme_pkg::ST_DIVZERO;
            state      <= S_EMIT;
          end else begin
            top   <= rd_data;
            state <= S_RD_BELOW;
          end
        end
        S_RD_BELOW: begin
          if (op == sme_pkg::OP_MUL) begin
            acc   <= '0;
            opa   <= rd_data;
            opb   <= top;
            iter  <= '0;
            state <= S_MUL;
          end else if (op == sme_pkg::OP_DIV) begin
            opb   <= rd_data;
            opa   <= top;
            neg   <= rd_data[W-1] ^ top[W-1];
            state <= S_ABS_A;
          end else begin
            acc   <= add_sum[W-1:0];
            state <= S_WB;
          end
        end
        S_MUL: begin
          // Shift-add multiply; only the low word is kept, which is sign-agnostic.
          acc  <= add_sum[W-1:0];
          opa  <= {opa[W-2:0], 1'b0};
          opb  <= {1'b0, opb[W-1:1]};
          iter <= iter + 1'b1;
          if (iter == ITER_LAST) begin
            state <= S_WB;
          end
        end
        S_ABS_A: begin
          if (opb[W-1]) begin
            opb <= add_sum[W-1:0];
          end
          state <= S_ABS_B;
        end
        S_ABS_B: begin
          if (opa[W-1]) begin
            opa <= add_sum[W-1:0];
          end
          rem   <= '0;
          iter  <= '0;
          state <= S_DIV;
        end
        S_DIV: begin
          // Restoring division: dividend bits leave opb at the top, quotient bits enter below.
          rem  <= div_ge ? add_sum[W-1:0] : {rem[W-2:0], opb[W-1]};
          opb  <= {opb[W-2:0], div_ge};
          iter <= iter + 1'b1;
          if (iter == ITER_LAST) begin
            state <= S_FIX;
          end
        end
        S_FIX: begin
          acc   <= neg ? add_sum[W-1:0] : opb;
          state <= S_WB;
        end
        S_WB: begin
          count      <= count_m1;
          res_status <= sme_pkg::ST_DONE;
          state      <= S_EMIT;
        end
        S_EMIT: begin
          if (!out_valid || !out_stall) begin
            out_valid   <= 1'b1;
            status      <= res_status;
            shown_value <= (res_status == sme_pkg::ST_SHOWN) ? acc : '0;
            depth       <= sme_pkg::DEPTH_W'(count);
            state       <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`include "stack_machine_executor_macros.svh"

  // The entry count never passes the stack size.
  `SME_ASSERT_NOW(a_count_bound, 1'b1, count <= CW'(STACK_DEPTH))
  // Once halted, the block stays halted until reset.
  `SME_ASSERT_NEXT(a_halt_sticky, halted, halted)
  // An instruction decoded while halted leaves the stack untouched.
  `SME_ASSERT_NEXT(a_halt_frozen, halted && (state == S_DECODE), $stable(count) && !mem_we)

endmodule
